>>> design/fsed_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths for the forbidden subgraph edge toggler.
// Used by the microcode ROM, the pattern evaluator, the top level and the checker.
package fsed_pkg;

   localparam int VTX_W      = 5;
   localparam int OP_W       = 2;
   localparam int OUTC_W     = 3;
   localparam int PAT_W      = 3;
   localparam int VCNT_W     = 6;
   localparam int TALLY_W    = 9;
   localparam int ROW_OUT_W  = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam int CMP_W      = 7;
   localparam int PC_W       = 5;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [OUTC_W-1:0] outcome_type;
   typedef logic [PAT_W-1:0]  pattern_type;
   typedef logic [PC_W-1:0]   pc_type;
   typedef logic [3:0]        act_type;
   typedef logic [3:0]        cond_type;

   localparam logic [TALLY_W-1:0] TALLY_MAX = 9'd511;

   localparam op_type OP_TOGGLE = 2'd0;
   localparam op_type OP_RESET  = 2'd1;
   localparam op_type OP_READ   = 2'd2;
   localparam op_type OP_UNUSED = 2'd3;

   localparam outcome_type OUT_REMOVED = 3'd0;
   localparam outcome_type OUT_ADDED   = 3'd1;
   localparam outcome_type OUT_FORBID  = 3'd2;
   localparam outcome_type OUT_IGNORED = 3'd3;
   localparam outcome_type OUT_RESET   = 3'd4;
   localparam outcome_type OUT_READ    = 3'd5;
   localparam outcome_type OUT_INVALID = 3'd6;

   localparam pattern_type PAT_TRI    = 3'd0;
   localparam pattern_type PAT_C4     = 3'd1;
   localparam pattern_type PAT_EITHER = 3'd2;
   localparam pattern_type PAT_K23    = 3'd3;
   localparam pattern_type PAT_HOUSE  = 3'd4;
   localparam pattern_type PAT_BULL   = 3'd5;
   localparam pattern_type PAT_BOWTIE = 3'd6;
   localparam pattern_type PAT_K4     = 3'd7;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VCOUNT  = 1'd1;

   // Datapath actions.
   localparam act_type A_NOP       = 4'd0;
   localparam act_type A_ACCEPT    = 4'd1;
   localparam act_type A_RDUV      = 4'd2;
   localparam act_type A_LDUV      = 4'd3;
   localparam act_type A_SCAN_INIT = 4'd4;
   localparam act_type A_OUT_RD    = 4'd5;
   localparam act_type A_OUT_LD    = 4'd6;
   localparam act_type A_IN        = 4'd7;
   localparam act_type A_I_INC     = 4'd8;
   localparam act_type A_WRU       = 4'd9;
   localparam act_type A_WRV       = 4'd10;
   localparam act_type A_EMIT      = 4'd11;

   // Jump conditions.
   localparam cond_type C_ALWAYS   = 4'd0;
   localparam cond_type C_NEVER    = 4'd1;
   localparam cond_type C_NOSTART  = 4'd2;
   localparam cond_type C_OP_RESET = 4'd3;
   localparam cond_type C_OP_READ  = 4'd4;
   localparam cond_type C_OP_BAD   = 4'd5;
   localparam cond_type C_OVER     = 4'd6;
   localparam cond_type C_BADEP    = 4'd7;
   localparam cond_type C_EDGE     = 4'd8;
   localparam cond_type C_SCAN_END = 4'd9;
   localparam cond_type C_NO_NEST  = 4'd10;
   localparam cond_type C_IN_MORE  = 4'd11;
   localparam cond_type C_HIT      = 4'd12;

   // Program addresses.
   localparam pc_type PC_IDLE     = 5'd0;
   localparam pc_type PC_RDUV     = 5'd1;
   localparam pc_type PC_LDUV     = 5'd2;
   localparam pc_type PC_CHK_READ = 5'd3;
   localparam pc_type PC_CHK_OP   = 5'd4;
   localparam pc_type PC_CHK_OVER = 5'd5;
   localparam pc_type PC_CHK_EP   = 5'd6;
   localparam pc_type PC_CHK_EDGE = 5'd7;
   localparam pc_type PC_SCAN     = 5'd8;
   localparam pc_type PC_OUT_RD   = 5'd9;
   localparam pc_type PC_OUT_LD   = 5'd10;
   localparam pc_type PC_NEST     = 5'd11;
   localparam pc_type PC_IN       = 5'd12;
   localparam pc_type PC_OUT_NEXT = 5'd13;
   localparam pc_type PC_DECIDE   = 5'd14;
   localparam pc_type PC_ADD_U    = 5'd15;
   localparam pc_type PC_ADD_V    = 5'd16;
   localparam pc_type PC_ADD_E    = 5'd17;
   localparam pc_type PC_RM_U     = 5'd18;
   localparam pc_type PC_RM_V     = 5'd19;
   localparam pc_type PC_RM_E     = 5'd20;
   localparam pc_type PC_E_FORBID = 5'd21;
   localparam pc_type PC_E_IGNORE = 5'd22;
   localparam pc_type PC_E_INVAL  = 5'd23;
   localparam pc_type PC_E_READ   = 5'd24;
   localparam pc_type PC_E_RESET  = 5'd25;

   typedef struct packed {
      act_type     act;
      cond_type    cond;
      pc_type      target;
      outcome_type outc;
   } ctrl_word_type;

   typedef struct packed {
      logic init_hit;
      logic outer_hit;
      logic nest;
      logic inner_hit;
   } eval_flags_type;

endpackage

>>> design/fsed_ucode_rom.sv
`timescale 1ns / 1ps
// Microcode ROM: one control word per program step.
// Depends on fsed_pkg for the action, condition and address codes.
module fsed_ucode_rom (
   input  fsed_pkg::pc_type        pc,
   output fsed_pkg::ctrl_word_type word
);
   import fsed_pkg::*;

   always_comb begin
      word = '{act: A_NOP, cond: C_ALWAYS, target: PC_IDLE, outc: OUT_INVALID};
      case (pc)
         PC_IDLE:     word = '{act: A_ACCEPT, cond: C_NOSTART, target: PC_IDLE, outc: OUT_INVALID};
         PC_RDUV:     word = '{act: A_RDUV, cond: C_NEVER, target: PC_IDLE, outc: OUT_INVALID};
         PC_LDUV:     word = '{act: A_LDUV, cond: C_OP_RESET, target: PC_E_RESET,
                               outc: OUT_INVALID};
         PC_CHK_READ: word = '{act: A_NOP, cond: C_OP_READ, target: PC_E_READ, outc: OUT_INVALID};
         PC_CHK_OP:   word = '{act: A_NOP, cond: C_OP_BAD, target: PC_E_INVAL, outc: OUT_INVALID};
         PC_CHK_OVER: word = '{act: A_NOP, cond: C_OVER, target: PC_E_IGNORE, outc: OUT_INVALID};
         PC_CHK_EP:   word = '{act: A_NOP, cond: C_BADEP, target: PC_E_INVAL, outc: OUT_INVALID};
         PC_CHK_EDGE: word = '{act: A_NOP, cond: C_EDGE, target: PC_RM_U, outc: OUT_INVALID};
         PC_SCAN:     word = '{act: A_SCAN_INIT, cond: C_NEVER, target: PC_IDLE,
                               outc: OUT_INVALID};
         PC_OUT_RD:   word = '{act: A_OUT_RD, cond: C_SCAN_END, target: PC_DECIDE,
                               outc: OUT_INVALID};
         PC_OUT_LD:   word = '{act: A_OUT_LD, cond: C_NEVER, target: PC_IDLE, outc: OUT_INVALID};
         PC_NEST:     word = '{act: A_NOP, cond: C_NO_NEST, target: PC_OUT_NEXT,
                               outc: OUT_INVALID};
         PC_IN:       word = '{act: A_IN, cond: C_IN_MORE, target: PC_IN, outc: OUT_INVALID};
         PC_OUT_NEXT: word = '{act: A_I_INC, cond: C_ALWAYS, target: PC_OUT_RD,
                               outc: OUT_INVALID};
         PC_DECIDE:   word = '{act: A_NOP, cond: C_HIT, target: PC_E_FORBID, outc: OUT_INVALID};
         PC_ADD_U:    word = '{act: A_WRU, cond: C_NEVER, target: PC_IDLE, outc: OUT_INVALID};
         PC_ADD_V:    word = '{act: A_WRV, cond: C_NEVER, target: PC_IDLE, outc: OUT_INVALID};
         PC_ADD_E:    word = '{act: A_EMIT, cond: C_ALWAYS, target: PC_IDLE, outc: OUT_ADDED};
         PC_RM_U:     word = '{act: A_WRU, cond: C_NEVER, target: PC_IDLE, outc: OUT_INVALID};
         PC_RM_V:     word = '{act: A_WRV, cond: C_NEVER, target: PC_IDLE, outc: OUT_INVALID};
         PC_RM_E:     word = '{act: A_EMIT, cond: C_ALWAYS, target: PC_IDLE, outc: OUT_REMOVED};
         PC_E_FORBID: word = '{act: A_EMIT, cond: C_ALWAYS, target: PC_IDLE, outc: OUT_FORBID};
         PC_E_IGNORE: word = '{act: A_EMIT, cond: C_ALWAYS, target: PC_IDLE, outc: OUT_IGNORED};
         PC_E_INVAL:  word = '{act: A_EMIT, cond: C_ALWAYS, target: PC_IDLE, outc: OUT_INVALID};
         PC_E_READ:   word = '{act: A_EMIT, cond: C_ALWAYS, target: PC_IDLE, outc: OUT_READ};
         PC_E_RESET:  word = '{act: A_EMIT, cond: C_ALWAYS, target: PC_IDLE, outc: OUT_RESET};
         default:     word = '{act: A_NOP, cond: C_ALWAYS, target: PC_IDLE, outc: OUT_INVALID};
      endcase
   end

endmodule

>>> design/fsed_adj_ram.sv
`timescale 1ns / 1ps
// Adjacency row memory: one write port, two registered read ports, and a
// valid bit per row so that reset and episode clear take effect at once.
module fsed_adj_ram #(
   parameter int ROW_W = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [ROW_W-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [ROW_W-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [ROW_W-1:0]         rd_data_b
);
   logic [ROW_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [ROW_W-1:0] rd_a_ff;
   logic [ROW_W-1:0] rd_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= valid_ff[rd_addr_a] ? mem[rd_addr_a] : '0;
      rd_b_ff <= valid_ff[rd_addr_b] ? mem[rd_addr_b] : '0;
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> design/fsed_pattern_eval.sv
`timescale 1ns / 1ps
// Pattern test unit: row-wide tests for the new edge (u, v) at one outer
// vertex and one inner vertex of the scan. Depends on fsed_pkg.
module fsed_pattern_eval #(
   parameter int ROW_W = 32,
   parameter int IDX_W = 5
) (
   input  fsed_pkg::pattern_type    pattern,
   input  logic [ROW_W-1:0]         row_u,
   input  logic [ROW_W-1:0]         row_v,
   input  logic [ROW_W-1:0]         ex_mask,
   input  logic [ROW_W-1:0]         outer_row,
   input  logic [IDX_W-1:0]         outer_idx,
   input  logic [ROW_W-1:0]         inner_row,
   input  logic [IDX_W-1:0]         inner_idx,
   output fsed_pkg::eval_flags_type flags
);
   import fsed_pkg::*;

   function automatic logic ge2(input logic [ROW_W-1:0] x);
      ge2 = (x & (x - ROW_W'(1))) != '0;
   endfunction

   // True when some p in a leaves b nonempty after removing p.
   function automatic logic pair_ok(input logic [ROW_W-1:0] a, input logic [ROW_W-1:0] b);
      pair_ok = (a != '0) && (b != '0) && (ge2(b) || ((a & ~b) != '0));
   endfunction

   always_comb begin
      logic [ROW_W-1:0] com, bi, bj, t, ax, bx, ri, rj;
      logic ui, vi, ci, tri_hit, c4, k23, k4, bull2;
      logic h_nest, b_nest, house, bull1, bowtie;
      com = row_u & row_v;
      ri  = outer_row;
      rj  = inner_row;
      bi  = ROW_W'(1) << outer_idx;
      bj  = ROW_W'(1) << inner_idx;
      t   = ex_mask | bi;
      ax  = row_u & ~ex_mask;
      bx  = row_v & ~ex_mask;
      ui  = |(row_u & bi);
      vi  = |(row_v & bi);
      ci  = |(com & bi);

      tri_hit = com != '0;
      c4      = ui && ((ri & row_v) != '0);
      k23     = (vi && ge2(row_u & ri)) || (ui && ge2(row_v & ri));
      k4      = ci && ((com & ri) != '0);
      bull2   = ci && (pair_ok(row_u & ~t, row_v & ~t) || pair_ok(row_v & ~t, ri & ~t) ||
                       pair_ok(row_u & ~t, ri & ~t));

      h_nest = ci || ui || vi;
      b_nest = |(ax & bi) || |(bx & bi);

      // House: the five ways the new edge can sit in a square with a roof.
      house = (ci && |(row_u & ~bi & bj) && |(row_v & rj & ~bi)) ||
              (ci && |(ri & ~ex_mask & bj) && |(rj & (row_u | row_v) & ~ex_mask & ~bi)) ||
              (ui && |(row_v & ri & bj) && |(ri & rj & ~ex_mask)) ||
              (vi && |(ri & row_u & bj) && |(row_u & rj & ~bi)) ||
              (ui && |(ri & row_v & bj) && |(row_v & rj & ~bi));
      bull1 = (|(ax & bi) && |(ax & ri & bj) && |((ri | rj) & ~ex_mask & ~bi & ~bj)) ||
              (|(bx & bi) && |(bx & ri & bj) && |((ri | rj) & ~ex_mask & ~bi & ~bj));
      bowtie = ci && ((|(row_u & ~t & bj) && |(row_u & rj & ~t)) ||
                      (|(row_v & ~t & bj) && |(row_v & rj & ~t)) ||
                      (|(ri & ~t & bj) && |(ri & rj & ~t)));

      flags = '0;
      case (pattern)
         PAT_TRI: begin
            flags.init_hit = tri_hit;
         end
         PAT_C4: begin
            flags.outer_hit = c4;
         end
         PAT_EITHER: begin
            flags.init_hit  = tri_hit;
            flags.outer_hit = c4;
         end
         PAT_K23: begin
            flags.outer_hit = k23;
         end
         PAT_HOUSE: begin
            flags.nest      = h_nest;
            flags.inner_hit = house;
         end
         PAT_BULL: begin
            flags.outer_hit = bull2;
            flags.nest      = b_nest;
            flags.inner_hit = bull1;
         end
         PAT_BOWTIE: begin
            flags.nest      = ci;
            flags.inner_hit = bowtie;
         end
         PAT_K4: begin
            flags.outer_hit = k4;
         end
         default: begin
            flags = '0;
         end
      endcase
   end

endmodule

>>> design/forbidden_subgraph_edge_toggler.sv
`timescale 1ns / 1ps
// Forbidden subgraph edge toggler. The program handles an episode reset first, then a read, an
// unknown operation, an ignored toggle in an ended episode and bad endpoints, in that order; an
// existing edge is removed, and a new edge is added only after a scan finds no forbidden pattern,
// the inner scan reading one row per cycle for each outer vertex that needs it.
// One transaction at a time; busy drops in the strobe cycle, so the next one can be accepted.
// Synchronous reset clears the graph, edge count and episode flag and restores the registers.
module forbidden_subgraph_edge_toggler #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  fsed_pkg::op_type                    req_operation,
   input  logic [fsed_pkg::VTX_W-1:0]          req_first_vertex,
   input  logic [fsed_pkg::VTX_W-1:0]          req_second_vertex,
   output logic                                rsp_valid,
   output fsed_pkg::outcome_type               rsp_outcome,
   output logic [fsed_pkg::TALLY_W-1:0]        rsp_edge_total,
   output logic                                rsp_episode_ended,
   output logic [fsed_pkg::ROW_OUT_W-1:0]      rsp_neighbour_row,
   input  logic                                csr_write_enable,
   input  logic [fsed_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fsed_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import fsed_pkg::*;

   localparam int ROW_W = MAX_VERTICES;
   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   ctrl_word_type  cw;
   eval_flags_type flags;

   pc_type                pc_ff, pc_in;
   pattern_type           pattern_ff, pattern_in;
   logic [VCNT_W-1:0]     vcount_ff, vcount_in;
   op_type                op_ff, op_in;
   logic [VTX_W-1:0]      u_ff, u_in, v_ff, v_in;
   logic [ROW_W-1:0]      ru_ff, ru_in, rv_ff, rv_in, ri_ff, ri_in, orow_ff, orow_in;
   logic [CNT_W-1:0]      i_ff, i_in, j_ff, j_in;
   logic [IDX_W-1:0]      jd_ff, jd_in;
   logic                  pend_ff, pend_in, nest_ff, nest_in, hit_ff, hit_in;
   logic [TALLY_W-1:0]    tally_ff, tally_in;
   logic                  over_ff, over_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   outcome_type           outc_ff, outc_in;
   logic [ROW_W-1:0]      out_row_ff, out_row_in;

   logic [CMP_W-1:0]      vc7, n7, u7, v7, i7, j7;
   logic [ROW_W-1:0]      act_mask, u_bit, v_bit, a_m, b_m, j_m, outer_sel;
   logic [ROW_W-1:0]      rd_a, rd_b, wr_data;
   logic [IDX_W-1:0]      rd_addr_a, rd_addr_b, wr_addr;
   logic                  wr_en, clear, cond_true, emit;

   fsed_ucode_rom u_rom (
      .pc   (pc_ff),
      .word (cw)
   );

   fsed_adj_ram #(
      .ROW_W (ROW_W),
      .DEPTH (MAX_VERTICES)
   ) u_ram (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_b)
   );

   fsed_pattern_eval #(
      .ROW_W (ROW_W),
      .IDX_W (IDX_W)
   ) u_eval (
      .pattern   (pattern_ff),
      .row_u     (a_m),
      .row_v     (b_m),
      .ex_mask   (u_bit | v_bit),
      .outer_row (outer_sel),
      .outer_idx (i_ff[IDX_W-1:0]),
      .inner_row (j_m),
      .inner_idx (jd_ff),
      .flags     (flags)
   );

   always_comb begin
      vc7 = CMP_W'(vcount_ff);
      n7  = (vc7 > CMP_W'(MAX_VERTICES)) ? CMP_W'(MAX_VERTICES) : vc7;
      u7  = CMP_W'(u_ff);
      v7  = CMP_W'(v_ff);
      i7  = CMP_W'(i_ff);
      j7  = CMP_W'(j_ff);
      for (int k = 0; k < ROW_W; k++) begin
         act_mask[k] = CMP_W'(k) < n7;
      end
   end

   assign u_bit     = ROW_W'(1) << u_ff;
   assign v_bit     = ROW_W'(1) << v_ff;
   assign a_m       = ru_ff & act_mask;
   assign b_m       = rv_ff & act_mask;
   assign j_m       = rd_a & act_mask;
   assign outer_sel = (cw.act == A_OUT_LD) ? j_m : ri_ff;
   assign emit      = cw.act == A_EMIT;
   assign clear     = emit && (cw.outc == OUT_RESET);

   // Read port A follows the program: row u, then the outer and inner scan rows.
   always_comb begin
      case (cw.act)
         A_OUT_RD: rd_addr_a = i_ff[IDX_W-1:0];
         A_IN:     rd_addr_a = j_ff[IDX_W-1:0];
         default:  rd_addr_a = IDX_W'(u_ff);
      endcase
   end
   assign rd_addr_b = IDX_W'(v_ff);

   assign wr_en   = (cw.act == A_WRU) || (cw.act == A_WRV);
   assign wr_addr = (cw.act == A_WRU) ? IDX_W'(u_ff) : IDX_W'(v_ff);
   assign wr_data = (cw.act == A_WRU) ? (ru_ff ^ v_bit) : (rv_ff ^ u_bit);

   always_comb begin
      case (cw.cond)
         C_ALWAYS:   cond_true = 1'b1;
         C_NEVER:    cond_true = 1'b0;
         C_NOSTART:  cond_true = !start;
         C_OP_RESET: cond_true = op_ff == OP_RESET;
         C_OP_READ:  cond_true = op_ff == OP_READ;
         C_OP_BAD:   cond_true = op_ff == OP_UNUSED;
         C_OVER:     cond_true = over_ff;
         C_BADEP:    cond_true = (u_ff == v_ff) || (u7 >= n7) || (v7 >= n7);
         C_EDGE:     cond_true = (ru_ff & v_bit) != '0;
         C_SCAN_END: cond_true = hit_ff || (i7 >= n7);
         C_NO_NEST:  cond_true = hit_ff || !nest_ff;
         C_IN_MORE:  cond_true = !hit_ff && ((j7 < n7) || pend_ff);
         C_HIT:      cond_true = hit_ff;
         default:    cond_true = 1'b0;
      endcase
   end

   always_comb begin
      pc_in        = cond_true ? cw.target : pc_ff + PC_W'(1);
      pattern_in   = pattern_ff;
      vcount_in    = vcount_ff;
      op_in        = op_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      ru_in        = ru_ff;
      rv_in        = rv_ff;
      ri_in        = ri_ff;
      orow_in      = orow_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jd_in        = jd_ff;
      pend_in      = pend_ff;
      nest_in      = nest_ff;
      hit_in       = hit_ff;
      tally_in     = tally_ff;
      over_in      = over_ff;
      rsp_valid_in = 1'b0;
      outc_in      = outc_ff;
      out_row_in   = out_row_ff;

      if (csr_write_enable) begin
         case (csr_index)
            REG_PATTERN: pattern_in = csr_write_data[PAT_W-1:0];
            REG_VCOUNT:  vcount_in  = csr_write_data[VCNT_W-1:0];
            default:     pattern_in = pattern_ff;
         endcase
      end

      case (cw.act)
         A_ACCEPT: begin
            if (start) begin
               op_in = req_operation;
               u_in  = req_first_vertex;
               v_in  = req_second_vertex;
            end
         end
         A_LDUV: begin
            ru_in   = rd_a;
            rv_in   = rd_b;
            orow_in = rd_a;
         end
         A_SCAN_INIT: begin
            i_in   = '0;
            hit_in = flags.init_hit;
         end
         A_OUT_LD: begin
            ri_in   = j_m;
            hit_in  = hit_ff | flags.outer_hit;
            nest_in = flags.nest;
            j_in    = '0;
            pend_in = 1'b0;
         end
         A_IN: begin
            hit_in = hit_ff | (pend_ff & flags.inner_hit);
            if (j7 < n7) begin
               jd_in   = j_ff[IDX_W-1:0];
               j_in    = j_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         A_I_INC: begin
            i_in = i_ff + CNT_W'(1);
         end
         A_WRU: begin
            orow_in = ru_ff ^ v_bit;
         end
         A_EMIT: begin
            rsp_valid_in = 1'b1;
            outc_in      = cw.outc;
            out_row_in   = (u7 < n7) ? (orow_ff & act_mask) : '0;
            case (cw.outc)
               OUT_REMOVED: begin
                  if (tally_ff != '0) tally_in = tally_ff - TALLY_W'(1);
               end
               OUT_ADDED: begin
                  if (tally_ff != TALLY_MAX) tally_in = tally_ff + TALLY_W'(1);
               end
               OUT_FORBID: begin
                  over_in = 1'b1;
               end
               OUT_RESET: begin
                  tally_in   = '0;
                  over_in    = 1'b0;
                  out_row_in = '0;
               end
               default: begin
                  over_in = over_ff;
               end
            endcase
         end
         default: begin
            pend_in = pend_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         pattern_ff   <= PAT_C4;
         vcount_ff    <= VCNT_W'(32);
         tally_ff     <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         nest_ff      <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         pattern_ff   <= pattern_in;
         vcount_ff    <= vcount_in;
         tally_ff     <= tally_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         pend_ff      <= pend_in;
         nest_ff      <= nest_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      ru_ff      <= ru_in;
      rv_ff      <= rv_in;
      ri_ff      <= ri_in;
      orow_ff    <= orow_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      jd_ff      <= jd_in;
      outc_ff    <= outc_in;
      out_row_ff <= out_row_in;
   end

   assign busy              = pc_ff != PC_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = outc_ff;
   assign rsp_edge_total    = tally_ff;
   assign rsp_episode_ended = over_ff;
   assign rsp_neighbour_row = ROW_OUT_W'(out_row_ff);

endmodule

>>> design/fsed_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the forbidden subgraph edge toggler, bound to the top level.
// Depends on fsed_pkg for the outcome codes.
module fsed_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input fsed_pkg::outcome_type              rsp_outcome,
   input logic [fsed_pkg::TALLY_W-1:0]       rsp_edge_total,
   input logic                               rsp_episode_ended,
   input logic [fsed_pkg::ROW_OUT_W-1:0]     rsp_neighbour_row
);
   import fsed_pkg::*;

   // A result arrives only once the sequencer is back at rest.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result strobe while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted transaction did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("two results in a row");

   a_reset_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_RESET |->
         rsp_edge_total == '0 && !rsp_episode_ended && rsp_neighbour_row == '0)
      else $error("episode reset left state behind");

   a_forbid_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_FORBID || rsp_outcome == OUT_IGNORED) |->
         rsp_episode_ended) else $error("ended outcome without episode flag");

endmodule

bind forbidden_subgraph_edge_toggler fsed_checker u_checker (.*);
